FILE: rtl/egcs_pkg.sv
`timescale 1ns / 1ps
package egcs_pkg;

  typedef enum logic [1:0] {
    FN_ENCRYPT = 2'd0,
    FN_DECRYPT = 2'd1,
    FN_SIGN    = 2'd2,
    FN_VERIFY  = 2'd3
  } func_t;

  localparam logic [1:0] CFG_PRIME     = 2'd0;
  localparam logic [1:0] CFG_GENERATOR = 2'd1;
  localparam logic [1:0] CFG_PRIVATE   = 2'd2;

  localparam int unsigned FIXED_NONCE = 4;
  localparam int unsigned RST_PRIME   = 23;
  localparam int unsigned RST_GEN     = 5;
  localparam int unsigned RST_PRIV    = 6;

  // Operation codes of the shared modular unit.
  typedef enum logic [1:0] {
    UOP_MUL  = 2'd0,  // x*y mod m, bit serial
    UOP_DIV  = 2'd1,  // x / y and x % y, restoring, bit serial
    UOP_NONE = 2'd2
  } uop_t;

endpackage

FILE: rtl/egcs_serial_unit.sv
`timescale 1ns / 1ps
// Bit-serial modular multiply (MSB first double-and-add) and restoring
// divide. One bit of the operand per cycle.
module egcs_serial_unit #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  egcs_pkg::uop_t        op,
  input  logic [WORD_WIDTH-1:0] x,
  input  logic [WORD_WIDTH-1:0] y,
  input  logic [WORD_WIDTH-1:0] m,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] res,
  output logic [WORD_WIDTH-1:0] rem
);
  import egcs_pkg::*;

  localparam int CW = $clog2(WORD_WIDTH + 1);

  logic              busy_r;
  uop_t              op_r;
  logic [CW-1:0]     cnt_r;
  logic [WORD_WIDTH-1:0] acc_r, sh_r, xm_r, m_r;
  logic [WORD_WIDTH:0]   dbl, sum, rsh;
  logic [WORD_WIDTH-1:0] dbl_m, add_m;

  // Multiply step: acc = 2*acc mod m, then + x if bit set.
  always_comb begin
    dbl   = {acc_r, 1'b0};
    dbl_m = (dbl >= {1'b0, m_r}) ? WORD_WIDTH'(dbl - {1'b0, m_r})
                                 : dbl[WORD_WIDTH-1:0];
    sum   = {1'b0, dbl_m} + {1'b0, xm_r};
    add_m = (sum >= {1'b0, m_r}) ? WORD_WIDTH'(sum - {1'b0, m_r})
                                 : sum[WORD_WIDTH-1:0];
    // Divide step: remainder shifted with next dividend bit.
    rsh   = {acc_r, sh_r[WORD_WIDTH-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
      op_r   <= UOP_NONE;
    end else begin
      done <= 1'b0;
      if (go && !busy_r) begin
        busy_r <= 1'b1;
        op_r   <= op;
        cnt_r  <= CW'(WORD_WIDTH);
        acc_r  <= '0;
        m_r    <= (op == UOP_MUL) ? m : y;
        sh_r   <= (op == UOP_MUL) ? y : x;
        xm_r   <= x;
      end else if (busy_r) begin
        if (op_r == UOP_MUL) begin
          acc_r <= sh_r[WORD_WIDTH-1] ? add_m : dbl_m;
          sh_r  <= {sh_r[WORD_WIDTH-2:0], 1'b0};
        end else begin
          if (rsh >= {1'b0, m_r}) begin
            acc_r <= WORD_WIDTH'(rsh - {1'b0, m_r});
            sh_r  <= {sh_r[WORD_WIDTH-2:0], 1'b1};
          end else begin
            acc_r <= rsh[WORD_WIDTH-1:0];
            sh_r  <= {sh_r[WORD_WIDTH-2:0], 1'b0};
          end
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Multiply: result in acc. Divide: quotient in sh, remainder in acc.
  assign res = (op_r == UOP_MUL) ? acc_r : sh_r;
  assign rem = acc_r;

endmodule

FILE: rtl/elgamal_crypt_sign_engine.sv
`timescale 1ns / 1ps
// Run time is data dependent. Each modular multiply or divide is one call into
// the shared serial unit, an exponentiation up to 2*WORD_WIDTH+1 of them;
// verify runs four exponentiations.
// Throughput: one word at a time; busy is high until the result strobe.
// Reset (rst_n low, synchronous): config returns to p=23, alpha=5, a=6,
// sequencer idles. The receiver cannot stall: out_valid pulses one cycle.
module elgamal_crypt_sign_engine #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_func,
  input  logic [WORD_WIDTH-1:0] in_message,
  input  logic [WORD_WIDTH-1:0] in_word_first,
  input  logic [WORD_WIDTH-1:0] in_word_second,
  output logic                  out_valid,
  output logic [WORD_WIDTH-1:0] out_result_first,
  output logic [WORD_WIDTH-1:0] out_result_second,
  output logic                  out_signature_ok,
  output logic [WORD_WIDTH-1:0] out_public_key,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [WORD_WIDTH-1:0] cfg_data
);
  import egcs_pkg::*;

  localparam int W  = WORD_WIDTH;

  // Sequencer: each step is either a call into the serial unit or a
  // short bit of bookkeeping. Exponentiation is a subroutine (PW_*).
  typedef enum logic [5:0] {
    S_IDLE, S_RED_GEN, S_BETA_CALL, S_BETA_RET, S_DISPATCH,
    S_ENC_C1_RET, S_ENC_B4_RET, S_ENC_MRED, S_ENC_MUL,
    S_DEC_RED, S_DEC_S_RET, S_DEC_INV_RET, S_DEC_W2, S_DEC_MUL,
    S_SG_GCD, S_SG_GCD_STEP, S_SG_NEXTK, S_SG_GAM_RET,
    S_SG_INV, S_SG_INV_Q, S_SG_INV_M, S_SG_INV_S,
    S_SG_MRED, S_SG_ARED, S_SG_AG, S_SG_T, S_SG_D,
    S_VF_BG_RET, S_VF_RED, S_VF_GD_RET, S_VF_RHS, S_VF_LHS_RET,
    S_PW_RED, S_PW_LOOP, S_PW_MUL, S_PW_SQ,
    S_UWAIT, S_DONE
  } state_t;

  state_t state_r, ret_r, uret_r;
  func_t  func_r;
  logic [W-1:0] p_r, g_r, a_r, msg_r, w1_r, w2_r;
  logic [W-1:0] beta_r, r1_r, r2_r, t1_r, t2_r, k_r, n_r;
  logic         ok_r;
  // Exponentiation: base, exponent (shifted right each step), accumulator.
  logic [W-1:0] pb_r, pe_r, pacc_r;
  // Euclid registers.
  logic [W-1:0] e0_r, e1_r, s0_r, s1_r;
  // Unit interface.
  logic         u_go_r, u_done;
  uop_t         u_op_r;
  logic [W-1:0] u_x_r, u_y_r, u_m_r, u_res, u_rem, ures_r, urem_r;

  egcs_serial_unit #(.WORD_WIDTH(W)) u_unit (
    .clk, .rst_n, .go(u_go_r), .op(u_op_r), .x(u_x_r), .y(u_y_r), .m(u_m_r),
    .done(u_done), .res(u_res), .rem(u_rem)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  logic [W-1:0] one_mod_p, n_sub;
  always_comb begin
    one_mod_p = {{(W-1){1'b0}}, 1'b1};
    // sub_mod(t1, ures, n)
    n_sub = (t1_r >= ures_r) ? W'(t1_r - ures_r) : W'(t1_r + (n_r - ures_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      uret_r    <= S_IDLE;
      u_go_r    <= 1'b0;
      out_valid <= 1'b0;
      p_r <= W'(RST_PRIME);
      g_r <= W'(RST_GEN);
      a_r <= W'(RST_PRIV);
    end else begin
      out_valid <= 1'b0;
      u_go_r    <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              CFG_PRIME:     p_r <= cfg_data;
              CFG_GENERATOR: g_r <= cfg_data;
              CFG_PRIVATE:   a_r <= cfg_data;
              default: ;
            endcase
          end
          if (start) begin
            func_r <= func_t'(in_func);
            msg_r  <= in_message;
            w1_r   <= in_word_first;
            w2_r   <= in_word_second;
            r1_r <= '0; r2_r <= '0; ok_r <= 1'b0; beta_r <= '0;
            n_r  <= p_r - W'(1);
            state_r <= (p_r < W'(3)) ? S_DONE : S_BETA_CALL;
          end
        end
        // Generic wait for the serial unit, then jump to uret.
        S_UWAIT: begin
          if (u_done) begin
            ures_r  <= u_res;
            urem_r  <= u_rem;
            state_r <= uret_r;
          end
        end
        // pow(pb, pe) mod p: pb reduced first, result in pacc.
        S_PW_RED: begin
          u_op_r <= UOP_DIV; u_x_r <= pb_r; u_y_r <= p_r; u_go_r <= 1'b1;
          pacc_r <= one_mod_p;
          uret_r <= S_PW_LOOP; state_r <= S_UWAIT;
        end
        S_PW_LOOP: begin
          if (uret_r == S_PW_LOOP) pb_r <= urem_r;
          if (uret_r == S_PW_MUL) pacc_r <= ures_r;
          if (uret_r == S_PW_SQ) pb_r <= ures_r;
          uret_r <= S_PW_MUL;
          if (pe_r == '0) begin
            state_r <= ret_r;
          end else begin
            state_r <= S_PW_MUL;
          end
        end
        S_PW_MUL: begin
          if (uret_r == S_PW_MUL) begin
            if (pe_r[0]) begin
              u_op_r <= UOP_MUL; u_x_r <= pacc_r; u_y_r <= pb_r; u_m_r <= p_r;
              u_go_r <= 1'b1; uret_r <= S_PW_SQ; state_r <= S_UWAIT;
            end else begin
              uret_r <= S_PW_SQ; state_r <= S_PW_SQ;
            end
          end else begin
            state_r <= S_PW_SQ;
          end
        end
        S_PW_SQ: begin
          // arriving from a multiply: store acc
          if (pe_r[0]) pacc_r <= ures_r;
          u_op_r <= UOP_MUL; u_x_r <= pb_r; u_y_r <= pb_r; u_m_r <= p_r;
          u_go_r <= 1'b1;
          pe_r   <= pe_r >> 1;
          uret_r <= S_PW_LOOP; state_r <= S_UWAIT;
          // the return state is held unchanged
          ret_r  <= ret_r;
        end
        S_RED_GEN: state_r <= S_BETA_CALL;
        S_BETA_CALL: begin
          pb_r <= g_r; pe_r <= a_r; ret_r <= S_BETA_RET; state_r <= S_PW_RED;
        end
        S_BETA_RET: begin
          beta_r <= pacc_r; state_r <= S_DISPATCH;
        end
        S_DISPATCH: begin
          unique case (func_r)
            FN_ENCRYPT: begin
              pb_r <= g_r; pe_r <= W'(FIXED_NONCE); ret_r <= S_ENC_C1_RET;
              state_r <= S_PW_RED;
            end
            FN_DECRYPT: begin
              pb_r <= w1_r; pe_r <= a_r; ret_r <= S_DEC_S_RET; state_r <= S_PW_RED;
            end
            FN_SIGN: begin
              k_r <= W'(FIXED_NONCE); state_r <= S_SG_GCD;
            end
            FN_VERIFY: begin
              if (w1_r != '0 && w1_r < p_r) begin
                pb_r <= beta_r; pe_r <= w1_r; ret_r <= S_VF_BG_RET;
                state_r <= S_PW_RED;
              end else state_r <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        // ---- encrypt
        S_ENC_C1_RET: begin
          r1_r <= pacc_r;
          pb_r <= beta_r; pe_r <= W'(FIXED_NONCE); ret_r <= S_ENC_B4_RET;
          state_r <= S_PW_RED;
        end
        S_ENC_B4_RET: begin
          t1_r <= pacc_r;
          u_op_r <= UOP_DIV; u_x_r <= msg_r; u_y_r <= p_r; u_go_r <= 1'b1;
          uret_r <= S_ENC_MUL; state_r <= S_UWAIT;
        end
        S_ENC_MUL: begin
          u_op_r <= UOP_MUL; u_x_r <= urem_r; u_y_r <= t1_r; u_m_r <= p_r;
          u_go_r <= 1'b1; uret_r <= S_ENC_MRED; state_r <= S_UWAIT;
        end
        S_ENC_MRED: begin r2_r <= ures_r; state_r <= S_DONE; end
        // ---- decrypt
        S_DEC_S_RET: begin
          pb_r <= pacc_r; pe_r <= p_r - W'(2); ret_r <= S_DEC_INV_RET;
          state_r <= S_PW_RED;
        end
        S_DEC_INV_RET: begin
          t1_r <= pacc_r;
          u_op_r <= UOP_DIV; u_x_r <= w2_r; u_y_r <= p_r; u_go_r <= 1'b1;
          uret_r <= S_DEC_W2; state_r <= S_UWAIT;
        end
        S_DEC_W2: begin
          u_op_r <= UOP_MUL; u_x_r <= urem_r; u_y_r <= t1_r; u_m_r <= p_r;
          u_go_r <= 1'b1; uret_r <= S_DEC_MUL; state_r <= S_UWAIT;
        end
        S_DEC_MUL: begin r1_r <= ures_r; state_r <= S_DONE; end
        S_DEC_RED: state_r <= S_DONE;
        // ---- sign: gcd(k, n) by repeated remainders
        S_SG_GCD: begin
          e0_r <= k_r; e1_r <= n_r; state_r <= S_SG_GCD_STEP;
          uret_r <= S_SG_GCD;
        end
        S_SG_GCD_STEP: begin
          if (uret_r == S_SG_GCD_STEP) begin
            e0_r <= e1_r; e1_r <= urem_r;
            uret_r <= S_SG_GCD;
          end else if (e1_r == '0) begin
            if (e0_r == W'(1)) begin
              pb_r <= g_r; pe_r <= k_r; ret_r <= S_SG_GAM_RET;
              state_r <= S_PW_RED;
            end else state_r <= S_SG_NEXTK;
          end else begin
            u_op_r <= UOP_DIV; u_x_r <= e0_r; u_y_r <= e1_r; u_go_r <= 1'b1;
            uret_r <= S_SG_GCD_STEP; state_r <= S_UWAIT;
          end
        end
        S_SG_NEXTK: begin
          // k = (k+1) % n, zero wraps to one
          if (W'(k_r + W'(1)) == n_r || k_r + W'(1) == '0) k_r <= W'(1);
          else if (k_r + W'(1) > n_r) begin
            // initial k above n (tiny p): reduce via unit
            u_op_r <= UOP_DIV; u_x_r <= k_r + W'(1); u_y_r <= n_r;
            u_go_r <= 1'b1; uret_r <= S_SG_INV_M; state_r <= S_UWAIT;
          end else k_r <= k_r + W'(1);
          if (!(k_r + W'(1) > n_r && W'(k_r + W'(1)) != n_r && k_r + W'(1) != '0))
            state_r <= S_SG_GCD;
        end
        S_SG_INV_M: begin
          k_r <= (urem_r == '0) ? W'(1) : urem_r; state_r <= S_SG_GCD;
        end
        S_SG_GAM_RET: begin
          r1_r <= pacc_r;
          // inverse of k mod n: extended Euclid, coefficients mod n
          u_op_r <= UOP_DIV; u_x_r <= k_r; u_y_r <= n_r; u_go_r <= 1'b1;
          uret_r <= S_SG_INV; state_r <= S_UWAIT;
        end
        S_SG_INV: begin
          e0_r <= n_r; e1_r <= urem_r; s0_r <= '0;
          s1_r <= (n_r == W'(1)) ? '0 : W'(1);
          state_r <= S_SG_INV_Q;
        end
        S_SG_INV_Q: begin
          if (e1_r > W'(1)) begin
            u_op_r <= UOP_DIV; u_x_r <= e0_r; u_y_r <= e1_r; u_go_r <= 1'b1;
            uret_r <= S_SG_INV_S; state_r <= S_UWAIT;
          end else begin
            t2_r <= (e1_r == W'(1)) ? s1_r : '0;
            u_op_r <= UOP_DIV; u_x_r <= msg_r; u_y_r <= n_r; u_go_r <= 1'b1;
            uret_r <= S_SG_MRED; state_r <= S_UWAIT;
          end
        end
        S_SG_INV_S: begin
          e0_r <= e1_r; e1_r <= urem_r;
          u_op_r <= UOP_MUL; u_x_r <= ures_r; u_y_r <= s1_r; u_m_r <= n_r;
          u_go_r <= 1'b1; uret_r <= S_SG_T; state_r <= S_UWAIT;
        end
        S_SG_T: begin
          if (func_r == FN_SIGN && ret_r != S_SG_D) begin
            // s2 = s0 - q*s1 mod n
            s0_r <= s1_r;
            s1_r <= (s0_r >= ures_r) ? W'(s0_r - ures_r)
                                     : W'(s0_r + (n_r - ures_r));
            state_r <= S_SG_INV_Q;
          end else state_r <= S_DONE;
        end
        S_SG_MRED: begin
          t1_r <= urem_r;
          u_op_r <= UOP_DIV; u_x_r <= a_r; u_y_r <= n_r; u_go_r <= 1'b1;
          uret_r <= S_SG_ARED; state_r <= S_UWAIT;
        end
        S_SG_ARED: begin
          u_op_r <= UOP_MUL; u_x_r <= urem_r; u_y_r <= r1_r; u_m_r <= n_r;
          u_go_r <= 1'b1; uret_r <= S_SG_AG; state_r <= S_UWAIT;
        end
        S_SG_AG: begin
          // gamma < p may equal n: it went into the unit as y, the shifted
          // multiplier, so it was not reduced first
          u_op_r <= UOP_MUL; u_x_r <= t2_r; u_y_r <= n_sub; u_m_r <= n_r;
          u_go_r <= 1'b1; uret_r <= S_SG_D; state_r <= S_UWAIT;
        end
        S_SG_D: begin r2_r <= ures_r; state_r <= S_DONE; end
        // ---- verify
        S_VF_BG_RET: begin
          t1_r <= pacc_r;
          pb_r <= w1_r; pe_r <= w2_r; ret_r <= S_VF_GD_RET; state_r <= S_PW_RED;
        end
        S_VF_GD_RET: begin
          u_op_r <= UOP_MUL; u_x_r <= t1_r; u_y_r <= pacc_r; u_m_r <= p_r;
          u_go_r <= 1'b1; uret_r <= S_VF_RHS; state_r <= S_UWAIT;
        end
        S_VF_RHS: begin
          t2_r <= ures_r;
          pb_r <= g_r; pe_r <= msg_r; ret_r <= S_VF_LHS_RET; state_r <= S_PW_RED;
        end
        S_VF_LHS_RET: begin ok_r <= (pacc_r == t2_r); state_r <= S_DONE; end
        S_VF_RED: state_r <= S_DONE;
        S_DONE: begin
          out_valid         <= 1'b1;
          out_result_first  <= r1_r;
          out_result_second <= r2_r;
          out_signature_ok  <= ok_r;
          out_public_key    <= beta_r;
          state_r           <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
